// ----- rtl/utcts_pkg.sv -----
// Shared types and constants of the UTC timestamp parser.
// Field widths, configuration register codes and the record passed from
// the character scanner through the queue into the epoch pipeline.
`default_nettype none

package utcts_pkg;

    localparam int YEAR_W      = 14;
    localparam int FIELD_W     = 7;
    localparam int MILLI_W     = 10;
    localparam int EPOCH_W     = 38;
    localparam int WINDOW_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_YEAR_LO = 2'd0,
        REG_YEAR_HI = 2'd1,
        REG_WINDOW  = 2'd2
    } cfg_reg_t;

    localparam logic [YEAR_W-1:0]   YEAR_LO_RST = 14'd2026;
    localparam logic [YEAR_W-1:0]   YEAR_HI_RST = 14'd2099;
    localparam logic [WINDOW_W-1:0] WINDOW_RST  = 16'd10;

    // One parsed stamp, as seen at its final character
    typedef struct packed {
        logic               scan_ok;   // length, separators and digits good
        logic               expiry;
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [MILLI_W-1:0] milli;
    } utcts_rec_t;

endpackage

`default_nettype wire

// ----- rtl/utc_timestamp_parser.sv -----
// Top level of the UTC timestamp parser: configuration registers, scanner,
// record queue and epoch pipeline. Depends on utcts_pkg, utcts_front,
// utcts_fifo and utcts_back.
`default_nettype none

// Parses YYYY-MM-DDTHH:MM:SS.mmmZ stamps fed one character per word and
// returns one result word per stamp, on the word flagged last_char. The
// scanner takes one character every cycle; it stalls only while the record
// queue (QUEUE_DEPTH entries) is full, which happens only if the result side
// is held off for several stamps. A result passes through the queue and four
// pipeline stages (range checks with the divisions by 25, day count, the
// days-times-86400 multiply, the epoch sum), then the output register, where
// an expiry stamp is checked against the stored source. Results leave in
// stamp order, and the pipeline takes a new stamp every cycle while the
// output is not stalled.
// Write the year limits and window_seconds only while no stamp is in flight.
module utc_timestamp_parser
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [utcts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [utcts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         char_code,
    input  logic                               last_char,
    input  logic                               stamp_role,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               format_ok,
    output logic [utcts_pkg::YEAR_W-1:0]       year_out,
    output logic [utcts_pkg::FIELD_W-1:0]      month_out,
    output logic [utcts_pkg::FIELD_W-1:0]      day_out,
    output logic [utcts_pkg::FIELD_W-1:0]      hour_out,
    output logic [utcts_pkg::FIELD_W-1:0]      minute_out,
    output logic [utcts_pkg::FIELD_W-1:0]      second_out,
    output logic [utcts_pkg::MILLI_W-1:0]      milli_out,
    output logic [utcts_pkg::EPOCH_W-1:0]      epoch_seconds,
    output logic                               window_ok
);
    import utcts_pkg::*;

    logic [YEAR_W-1:0]   year_lo_reg;
    logic [YEAR_W-1:0]   year_hi_reg;
    logic [WINDOW_W-1:0] window_reg;

    logic       queue_full;
    logic       push;
    utcts_rec_t push_rec;
    logic       pop;
    logic       head_valid;
    utcts_rec_t head_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_lo_reg <= YEAR_LO_RST;
            year_hi_reg <= YEAR_HI_RST;
            window_reg  <= WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_YEAR_LO: year_lo_reg <= cfg_data[YEAR_W-1:0];
                REG_YEAR_HI: year_hi_reg <= cfg_data[YEAR_W-1:0];
                REG_WINDOW:  window_reg  <= cfg_data[WINDOW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    utcts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .stamp_role (stamp_role),
        .queue_full (queue_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    utcts_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    utcts_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_rec       (head_rec),
        .pop            (pop),
        .year_lo        (year_lo_reg),
        .year_hi        (year_hi_reg),
        .window_seconds (window_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .format_ok      (format_ok),
        .year_out       (year_out),
        .month_out      (month_out),
        .day_out        (day_out),
        .hour_out       (hour_out),
        .minute_out     (minute_out),
        .second_out     (second_out),
        .milli_out      (milli_out),
        .epoch_seconds  (epoch_seconds),
        .window_ok      (window_ok)
    );

endmodule

`default_nettype wire

// ----- rtl/utcts_front.sv -----
// Character scanner: checks each character against its position and
// gathers the digits into the seven fields; emits one record per stamp.
// Depends on utcts_pkg.
`default_nettype none

module utcts_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           char_code,
    input  logic                 last_char,
    input  logic                 stamp_role,
    input  logic                 queue_full,
    output logic                 push,
    output utcts_pkg::utcts_rec_t push_rec
);
    import utcts_pkg::*;

    typedef enum logic [2:0] {
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND,
        FLD_MILLI,
        FLD_SEP
    } field_sel_t;

    localparam logic [4:0] STAMP_LEN = 5'd24;
    localparam logic [4:0] LAST_POS  = 5'd23;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    function automatic field_sel_t pos_field(input logic [4:0] pos);
        unique case (pos)
            5'd0, 5'd1, 5'd2, 5'd3: pos_field = FLD_YEAR;
            5'd5, 5'd6:             pos_field = FLD_MONTH;
            5'd8, 5'd9:             pos_field = FLD_DAY;
            5'd11, 5'd12:           pos_field = FLD_HOUR;
            5'd14, 5'd15:           pos_field = FLD_MINUTE;
            5'd17, 5'd18:           pos_field = FLD_SECOND;
            5'd20, 5'd21, 5'd22:    pos_field = FLD_MILLI;
            default:                pos_field = FLD_SEP;
        endcase
    endfunction

    function automatic logic [7:0] pos_sep(input logic [4:0] pos);
        unique case (pos)
            5'd4, 5'd7:   pos_sep = 8'h2D;  // '-'
            5'd10:        pos_sep = 8'h54;  // 'T'
            5'd13, 5'd16: pos_sep = 8'h3A;  // ':'
            5'd19:        pos_sep = 8'h2E;  // '.'
            5'd23:        pos_sep = 8'h5A;  // 'Z'
            default:      pos_sep = 8'h00;
        endcase
    endfunction

    // acc * 10 + digit, kept to the accumulator width
    function automatic logic [YEAR_W-1:0] dec_step(input logic [YEAR_W-1:0] acc,
                                                   input logic [3:0] digit);
        logic [YEAR_W+2:0] t;
        t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(YEAR_W-1){1'b0}}, digit};
        dec_step = t[YEAR_W-1:0];
    endfunction

    logic [4:0]         pos_reg;
    logic               over_reg;
    logic               syn_reg;
    logic [YEAR_W-1:0]  year_acc_reg;
    logic [FIELD_W-1:0] month_acc_reg;
    logic [FIELD_W-1:0] day_acc_reg;
    logic [FIELD_W-1:0] hour_acc_reg;
    logic [FIELD_W-1:0] minute_acc_reg;
    logic [FIELD_W-1:0] second_acc_reg;
    logic [MILLI_W-1:0] milli_acc_reg;

    logic               accept;
    logic               in_range;
    field_sel_t         fsel;
    logic               is_digit;
    logic               take;
    logic [3:0]         digit;
    logic               over_now;
    logic               syn_now;
    logic [YEAR_W-1:0]  month_wide;
    logic [YEAR_W-1:0]  day_wide;
    logic [YEAR_W-1:0]  hour_wide;
    logic [YEAR_W-1:0]  minute_wide;
    logic [YEAR_W-1:0]  second_wide;
    logic [YEAR_W-1:0]  milli_wide;
    logic [YEAR_W-1:0]  year_next;
    logic [FIELD_W-1:0] month_next;
    logic [FIELD_W-1:0] day_next;
    logic [FIELD_W-1:0] hour_next;
    logic [FIELD_W-1:0] minute_next;
    logic [FIELD_W-1:0] second_next;
    logic [MILLI_W-1:0] milli_next;

    always_comb
    begin
        accept    = in_valid && !queue_full;
        in_range  = pos_reg < STAMP_LEN;
        fsel      = in_range ? pos_field(pos_reg) : FLD_SEP;
        is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        take      = in_range && is_digit;
        digit     = char_code[3:0];

        over_now  = over_reg || !in_range;
        syn_now   = syn_reg
                    || (in_range && (fsel == FLD_SEP) && (char_code != pos_sep(pos_reg)))
                    || (in_range && (fsel != FLD_SEP) && !is_digit);

        month_wide  = dec_step({{(YEAR_W-FIELD_W){1'b0}}, month_acc_reg}, digit);
        day_wide    = dec_step({{(YEAR_W-FIELD_W){1'b0}}, day_acc_reg}, digit);
        hour_wide   = dec_step({{(YEAR_W-FIELD_W){1'b0}}, hour_acc_reg}, digit);
        minute_wide = dec_step({{(YEAR_W-FIELD_W){1'b0}}, minute_acc_reg}, digit);
        second_wide = dec_step({{(YEAR_W-FIELD_W){1'b0}}, second_acc_reg}, digit);
        milli_wide  = dec_step({{(YEAR_W-MILLI_W){1'b0}}, milli_acc_reg}, digit);

        year_next   = (take && fsel == FLD_YEAR) ? dec_step(year_acc_reg, digit)
                                                 : year_acc_reg;
        month_next  = (take && fsel == FLD_MONTH)  ? month_wide[FIELD_W-1:0]  : month_acc_reg;
        day_next    = (take && fsel == FLD_DAY)    ? day_wide[FIELD_W-1:0]    : day_acc_reg;
        hour_next   = (take && fsel == FLD_HOUR)   ? hour_wide[FIELD_W-1:0]   : hour_acc_reg;
        minute_next = (take && fsel == FLD_MINUTE) ? minute_wide[FIELD_W-1:0] : minute_acc_reg;
        second_next = (take && fsel == FLD_SECOND) ? second_wide[FIELD_W-1:0] : second_acc_reg;
        milli_next  = (take && fsel == FLD_MILLI)  ? milli_wide[MILLI_W-1:0]  : milli_acc_reg;

        push             = accept && last_char;
        push_rec.scan_ok = !over_now && !syn_now && (pos_reg == LAST_POS);
        push_rec.expiry  = stamp_role;
        push_rec.year    = year_next;
        push_rec.month   = month_next;
        push_rec.day     = day_next;
        push_rec.hour    = hour_next;
        push_rec.minute  = minute_next;
        push_rec.second  = second_next;
        push_rec.milli   = milli_next;
    end

    assign in_stall = queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            over_reg       <= 1'b0;
            syn_reg        <= 1'b0;
            year_acc_reg   <= '0;
            month_acc_reg  <= '0;
            day_acc_reg    <= '0;
            hour_acc_reg   <= '0;
            minute_acc_reg <= '0;
            second_acc_reg <= '0;
            milli_acc_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                pos_reg        <= '0;
                over_reg       <= 1'b0;
                syn_reg        <= 1'b0;
                year_acc_reg   <= '0;
                month_acc_reg  <= '0;
                day_acc_reg    <= '0;
                hour_acc_reg   <= '0;
                minute_acc_reg <= '0;
                second_acc_reg <= '0;
                milli_acc_reg  <= '0;
            end
            else
            begin
                // position sticks at the end once the stamp runs long
                if (in_range)
                begin
                    pos_reg <= pos_reg + 5'd1;
                end
                over_reg       <= over_now;
                syn_reg        <= syn_now;
                year_acc_reg   <= year_next;
                month_acc_reg  <= month_next;
                day_acc_reg    <= day_next;
                hour_acc_reg   <= hour_next;
                minute_acc_reg <= minute_next;
                second_acc_reg <= second_next;
                milli_acc_reg  <= milli_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utcts_fifo.sv -----
// Short record queue between the character scanner and the epoch pipeline.
// Register storage, one write and one read per cycle. Depends on utcts_pkg.
`default_nettype none

module utcts_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  utcts_pkg::utcts_rec_t push_rec,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output utcts_pkg::utcts_rec_t head_rec
);
    import utcts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utcts_rec_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        full       = count_reg == CNT_W'(DEPTH);
        head_valid = count_reg != '0;
        head_rec   = mem_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utcts_back.sv -----
// Epoch pipeline: range checks, civil-days count, epoch seconds, window
// check against the stored source stamp, output register.
// Depends on utcts_pkg.
`default_nettype none

module utcts_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  utcts_pkg::utcts_rec_t            head_rec,
    output logic                             pop,
    input  logic [utcts_pkg::YEAR_W-1:0]     year_lo,
    input  logic [utcts_pkg::YEAR_W-1:0]     year_hi,
    input  logic [utcts_pkg::WINDOW_W-1:0]   window_seconds,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             format_ok,
    output logic [utcts_pkg::YEAR_W-1:0]     year_out,
    output logic [utcts_pkg::FIELD_W-1:0]    month_out,
    output logic [utcts_pkg::FIELD_W-1:0]    day_out,
    output logic [utcts_pkg::FIELD_W-1:0]    hour_out,
    output logic [utcts_pkg::FIELD_W-1:0]    minute_out,
    output logic [utcts_pkg::FIELD_W-1:0]    second_out,
    output logic [utcts_pkg::MILLI_W-1:0]    milli_out,
    output logic [utcts_pkg::EPOCH_W-1:0]    epoch_seconds,
    output logic                             window_ok
);
    import utcts_pkg::*;

    localparam int DAYS_W = 22;
    localparam int TOD_W  = 17;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR   = 14'd1970;
    localparam logic [23:0]        DIV25_MUL    = 24'd2622;  // ceil(2^16 / 25)
    localparam logic [23:0]        DAYS_OFFSET  = 24'd719469; // civil offset plus one
    localparam logic [TOD_W-1:0]   DAY_SECONDS  = 17'd86400;

    // x / 25 for x < 4096
    function automatic logic [7:0] div25(input logic [11:0] x);
        logic [23:0] p;
        p = {12'd0, x} * DIV25_MUL;
        div25 = p[23:16];
    endfunction

    function automatic logic [4:0] month_len(input logic [FIELD_W-1:0] m, input logic leap);
        unique case (m)
            7'd2:                          month_len = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:       month_len = 5'd30;
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12:
                                           month_len = 5'd31;
            default:                       month_len = 5'd0;
        endcase
    endfunction

    // days before the first of month m, counted from March 1
    function automatic logic [8:0] march_off(input logic [FIELD_W-1:0] m);
        unique case (m)
            7'd3:    march_off = 9'd0;
            7'd4:    march_off = 9'd31;
            7'd5:    march_off = 9'd61;
            7'd6:    march_off = 9'd92;
            7'd7:    march_off = 9'd122;
            7'd8:    march_off = 9'd153;
            7'd9:    march_off = 9'd184;
            7'd10:   march_off = 9'd214;
            7'd11:   march_off = 9'd245;
            7'd12:   march_off = 9'd275;
            7'd1:    march_off = 9'd306;
            7'd2:    march_off = 9'd337;
            default: march_off = 9'd0;
        endcase
    endfunction

    logic adv;

    // stage A: range checks and the divisions by 25
    logic               a_valid_reg;
    logic               a_ok_reg;
    utcts_rec_t         a_rec_reg;
    logic [YEAR_W-1:0]  a_yy_reg;
    logic [7:0]         a_q1_reg;
    logic [7:0]         a_q2_reg;
    logic [7:0]         a_zq_reg;

    logic               mar_early;
    logic [YEAR_W-1:0]  yy;
    logic               a_ok;

    // stage B: leap day check, day count, time of day
    logic               b_valid_reg;
    logic               b_ok_reg;
    utcts_rec_t         b_rec_reg;
    logic [DAYS_W-1:0]  b_days_reg;
    logic [TOD_W-1:0]   b_tod_reg;

    logic [11:0]        zq25;
    logic               div100;
    logic               leap;
    logic               b_ok;
    utcts_rec_t         b_rec;
    logic [23:0]        days_sum;
    logic [TOD_W-1:0]   tod;

    // stage C: days * 86400
    logic               c_valid_reg;
    logic               c_ok_reg;
    utcts_rec_t         c_rec_reg;
    logic [EPOCH_W-1:0] c_prod_reg;
    logic [TOD_W-1:0]   c_tod_reg;

    logic [EPOCH_W:0]   prod;

    // stage D: epoch seconds
    logic               d_valid_reg;
    logic               d_ok_reg;
    utcts_rec_t         d_rec_reg;
    logic [EPOCH_W-1:0] d_epoch_reg;

    // output word and stored source
    logic               out_valid_reg;
    logic               out_ok_reg;
    utcts_rec_t         out_rec_reg;
    logic [EPOCH_W-1:0] out_epoch_reg;
    logic               out_win_reg;
    logic               src_valid_reg;
    logic [EPOCH_W-1:0] src_sec_reg;
    logic [MILLI_W-1:0] src_milli_reg;

    logic [EPOCH_W:0]   src_sum;
    logic               win;

    always_comb
    begin
        adv = !out_valid_reg || !out_stall;
        pop = adv && head_valid;

        mar_early = head_rec.month <= 7'd2;
        yy        = head_rec.year - {{(YEAR_W-1){1'b0}}, mar_early};
        a_ok      = head_rec.scan_ok
                    && (head_rec.year >= EPOCH_YEAR)
                    && (head_rec.year >= year_lo) && (head_rec.year <= year_hi)
                    && (head_rec.month >= 7'd1) && (head_rec.month <= 7'd12)
                    && (head_rec.hour <= 7'd23) && (head_rec.minute <= 7'd59)
                    && (head_rec.second <= 7'd59) && (head_rec.milli <= 10'd999);

        // year / 100 is zq; a multiple of 4 is a century year when year/4 is a multiple of 25
        zq25   = {4'd0, a_zq_reg} * 12'd25;
        div100 = a_rec_reg.year[YEAR_W-1:2] == zq25;
        leap   = (a_rec_reg.year[1:0] == 2'b00) && (!div100 || a_zq_reg[1:0] == 2'b00);
        b_ok   = a_ok_reg && (a_rec_reg.day != 7'd0)
                 && (a_rec_reg.day <= {2'b00, month_len(a_rec_reg.month, leap)});

        // fields clear on a bad stamp, the role still steers the source update
        b_rec        = b_ok ? a_rec_reg : '0;
        b_rec.expiry = a_rec_reg.expiry;

        // 365*yy + yy/4 - yy/100 + yy/400 + day of March-based year - offset
        days_sum = {10'd0, a_yy_reg} * 24'd365
                   + {12'd0, a_yy_reg[YEAR_W-1:2]}
                   + {16'd0, a_q2_reg}
                   + {15'd0, march_off(a_rec_reg.month)}
                   + {17'd0, a_rec_reg.day}
                   - {16'd0, a_q1_reg}
                   - DAYS_OFFSET;
        tod      = {10'd0, a_rec_reg.hour} * 17'd3600
                   + {10'd0, a_rec_reg.minute} * 17'd60
                   + {10'd0, a_rec_reg.second};

        prod = {{(EPOCH_W+1-DAYS_W){1'b0}}, b_days_reg}
               * {{(EPOCH_W+1-TOD_W){1'b0}}, DAY_SECONDS};

        src_sum = {1'b0, src_sec_reg} + {{(EPOCH_W+1-WINDOW_W){1'b0}}, window_seconds};
        win     = d_rec_reg.expiry && d_ok_reg && src_valid_reg
                  && (d_rec_reg.milli == src_milli_reg)
                  && ({1'b0, d_epoch_reg} == src_sum);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ok_reg  <= a_ok;
            a_rec_reg <= head_rec;
            a_yy_reg  <= yy;
            a_q1_reg  <= div25(yy[YEAR_W-1:2]);
            a_q2_reg  <= div25({2'b00, yy[YEAR_W-1:4]});
            a_zq_reg  <= div25(head_rec.year[YEAR_W-1:2]);

            b_ok_reg   <= b_ok;
            b_rec_reg  <= b_rec;
            b_days_reg <= b_ok ? days_sum[DAYS_W-1:0] : '0;
            b_tod_reg  <= b_ok ? tod : '0;

            c_ok_reg   <= b_ok_reg;
            c_rec_reg  <= b_rec_reg;
            c_prod_reg <= prod[EPOCH_W-1:0];
            c_tod_reg  <= b_tod_reg;

            d_ok_reg    <= c_ok_reg;
            d_rec_reg   <= c_rec_reg;
            d_epoch_reg <= c_prod_reg + {{(EPOCH_W-TOD_W){1'b0}}, c_tod_reg};

            if (d_valid_reg)
            begin
                out_ok_reg    <= d_ok_reg;
                out_rec_reg   <= d_rec_reg;
                out_epoch_reg <= d_epoch_reg;
                out_win_reg   <= win;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            src_valid_reg <= 1'b0;
            src_sec_reg   <= '0;
            src_milli_reg <= '0;
        end
        else if (adv)
        begin
            a_valid_reg   <= head_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
            // a source stamp replaces the stored one, valid or not
            if (d_valid_reg && !d_rec_reg.expiry)
            begin
                src_valid_reg <= d_ok_reg;
                src_sec_reg   <= d_epoch_reg;
                src_milli_reg <= d_rec_reg.milli;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign format_ok     = out_ok_reg;
    assign year_out      = out_rec_reg.year;
    assign month_out     = out_rec_reg.month;
    assign day_out       = out_rec_reg.day;
    assign hour_out      = out_rec_reg.hour;
    assign minute_out    = out_rec_reg.minute;
    assign second_out    = out_rec_reg.second;
    assign milli_out     = out_rec_reg.milli;
    assign epoch_seconds = out_epoch_reg;
    assign window_ok     = out_win_reg;

endmodule

`default_nettype wire

// ----- bench/tb_utc_timestamp_parser.sv -----
// Testbench for utc_timestamp_parser: feeds timestamp characters one word at a time
// and checks every result word against an in-bench parser and epoch predictor.
// Depends on utcts_pkg and the utc_timestamp_parser RTL.
`default_nettype none

module tb_utc_timestamp_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import utcts_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_CHARS = 250;

    typedef bit [7:0] char_q_t[$];

    typedef struct packed {
        bit               ok;
        bit [YEAR_W-1:0]  year;
        bit [FIELD_W-1:0] month;
        bit [FIELD_W-1:0] day;
        bit [FIELD_W-1:0] hour;
        bit [FIELD_W-1:0] minute;
        bit [FIELD_W-1:0] second;
        bit [MILLI_W-1:0] milli;
        bit [EPOCH_W-1:0] epoch;
        bit               win;
    } stamp_result_t;

    typedef struct {
        bit            given;
        stamp_result_t want;
    } known_result_t;

    typedef enum bit {ROW_STAMP, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        cfg_reg_t      sel;
        int            value;
        string         text;
        bit            role;
        bit            given;
        stamp_result_t want;
    } directed_row_t;

    localparam stamp_result_t NO_STAMP = '0;
    localparam stamp_result_t STAMP_2026 =
        '{1'b1, 14'd2026, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0, 10'd0, 38'd1767225600, 1'b0};
    localparam stamp_result_t STAMP_1970 =
        '{1'b1, 14'd1970, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0, 10'd0, 38'd0, 1'b0};
    localparam stamp_result_t STAMP_9999 =
        '{1'b1, 14'd9999, 7'd12, 7'd31, 7'd23, 7'd59, 7'd59, 10'd999,
          38'd253402300799, 1'b0};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             char_code = '0;
    logic                   last_char = 1'b0;
    logic                   stamp_role = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   format_ok;
    logic [YEAR_W-1:0]      year_out;
    logic [FIELD_W-1:0]     month_out;
    logic [FIELD_W-1:0]     day_out;
    logic [FIELD_W-1:0]     hour_out;
    logic [FIELD_W-1:0]     minute_out;
    logic [FIELD_W-1:0]     second_out;
    logic [MILLI_W-1:0]     milli_out;
    logic [EPOCH_W-1:0]     epoch_seconds;
    logic                   window_ok;

    // predictor copy of the registers and of the parser state
    bit [YEAR_W-1:0]   cfg_min = YEAR_LO_RST;
    bit [YEAR_W-1:0]   cfg_max = YEAR_HI_RST;
    bit [WINDOW_W-1:0] cfg_window = WINDOW_RST;
    int                scan_pos;
    bit                over_seen;
    bit                syntax_seen;
    bit [YEAR_W-1:0]   acc [7];
    bit [EPOCH_W-1:0]  src_secs;
    bit [MILLI_W-1:0]  src_milli;
    bit                src_valid;

    stamp_result_t pending_results[$];
    known_result_t known_q[$];
    int            mismatches;
    int            quiet_cycles;

    directed_row_t plan [0:32] = '{
        '{ROW_STAMP, REG_YEAR_LO, 0, "2026-01-01T00:00:00.000Z", 1'b0, 1'b1, STAMP_2026},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2026-01-01T00:00:10.000Z", 1'b1, 1'b0, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2025-12-31T23:59:59.999Z", 1'b0, 1'b1, NO_STAMP},
        // expiry after an invalid source: no window match possible
        '{ROW_STAMP, REG_YEAR_LO, 0, "2026-01-01T00:00:10.000Z", 1'b1, 1'b0, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2100-01-01T00:00:00.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_CFG,   REG_YEAR_LO, 0,    "", 1'b0, 1'b0, NO_STAMP},
        '{ROW_CFG,   REG_YEAR_HI, 9999, "", 1'b0, 1'b0, NO_STAMP},
        '{ROW_CFG,   REG_WINDOW,  0,    "", 1'b0, 1'b0, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "1970-01-01T00:00:00.000Z", 1'b0, 1'b1, STAMP_1970},
        '{ROW_STAMP, REG_YEAR_LO, 0, "1970-01-01T00:00:00.000Z", 1'b1, 1'b0, NO_STAMP},
        // pre-epoch year stays out even with the lower year limit at zero
        '{ROW_STAMP, REG_YEAR_LO, 0, "1969-12-31T23:59:59.999Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "9999-12-31T23:59:59.999Z", 1'b0, 1'b1, STAMP_9999},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2000-02-29T12:30:45.500Z", 1'b0, 1'b0, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2100-02-29T00:00:00.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-04-31T00:00:00.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-13-01T00:00:00.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-00-10T00:00:00.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-01-00T00:00:00.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-01-01T24:00:00.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-01-01T23:60:59.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-01-01T23:59:60.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024/01-01T00:00:00.000Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "20a4-01-01T00:00:00.000z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-01-01T00:00:00.00Z", 1'b0, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-01-01T00:00:00.000ZZZ", 1'b0, 1'b1, NO_STAMP},
        '{ROW_CFG,   REG_WINDOW,  65535, "", 1'b0, 1'b0, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-06-15T10:20:30.123Z", 1'b0, 1'b0, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-06-16T04:32:45.123Z", 1'b1, 1'b0, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-06-16T04:32:45.124Z", 1'b1, 1'b0, NO_STAMP},
        // lower year limit above the upper one: nothing is accepted
        '{ROW_CFG,   REG_YEAR_LO, 3000, "", 1'b0, 1'b0, NO_STAMP},
        '{ROW_CFG,   REG_YEAR_HI, 2000, "", 1'b0, 1'b0, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2024-06-16T04:32:45.123Z", 1'b1, 1'b1, NO_STAMP},
        '{ROW_STAMP, REG_YEAR_LO, 0, "2500-01-01T00:00:00.000Z", 1'b0, 1'b1, NO_STAMP}
    };

    utc_timestamp_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .last_char     (last_char),
        .stamp_role    (stamp_role),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .format_ok     (format_ok),
        .year_out      (year_out),
        .month_out     (month_out),
        .day_out       (day_out),
        .hour_out      (hour_out),
        .minute_out    (minute_out),
        .second_out    (second_out),
        .milli_out     (milli_out),
        .epoch_seconds (epoch_seconds),
        .window_ok     (window_ok)
    );

    always #4 clk = ~clk;

    function automatic longint days_since_epoch(int y, int m, int d);
        longint yy;
        longint era;
        longint yoe;
        longint mp;
        longint doy;
        longint doe;
        begin
            yy  = y - ((m <= 2) ? 1 : 0);
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468;
        end
    endfunction

    function automatic string stamp_text(int y, int mo, int d, int h, int mi, int s, int ms);
        return $sformatf("%04d-%02d-%02dT%02d:%02d:%02d.%03dZ", y, mo, d, h, mi, s, ms);
    endfunction

    // civil date back from epoch seconds, to build expiry stamps that hit the window
    function automatic string stamp_from_epoch(longint secs, int ms);
        longint z;
        longint era;
        longint doe;
        longint yoe;
        longint doy;
        longint mp;
        longint d;
        longint m;
        longint y;
        longint rem;
        begin
            z   = secs / 86400 + 719468;
            rem = secs % 86400;
            era = z / 146097;
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            d   = doy - (153 * mp + 2) / 5 + 1;
            m   = (mp < 10) ? mp + 3 : mp - 9;
            y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
            return stamp_text(int'(y), int'(m), int'(d), int'(rem / 3600),
                              int'((rem % 3600) / 60), int'(rem % 60), ms);
        end
    endfunction

    function automatic char_q_t to_chars(string text);
        char_q_t chars;
        begin
            for (int i = 0; i < text.len(); i++)
                chars.push_back(text[i]);
            return chars;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] %s", $time, what);
        mismatches++;
    endtask

    // scanner and epoch predictor, one accepted character word per call
    task automatic parse_char(input bit [7:0] c, input bit last, input bit role);
        int            entry_pos;
        int            f;
        bit [7:0]      sep;
        int            y;
        int            mo;
        int            d;
        int            h;
        int            mi;
        int            s;
        int            ms;
        int            mlen;
        bit            leap;
        bit            ok;
        longint        secs;
        stamp_result_t res;
        known_result_t known;
        begin
            entry_pos = scan_pos;
            if (scan_pos >= 24) begin
                over_seen = 1'b1;
            end
            else begin
                f = -1;
                sep = 8'h00;
                case (scan_pos)
                    0, 1, 2, 3:  f = 0;
                    4, 7:        sep = "-";
                    5, 6:        f = 1;
                    8, 9:        f = 2;
                    10:          sep = "T";
                    11, 12:      f = 3;
                    13, 16:      sep = ":";
                    14, 15:      f = 4;
                    17, 18:      f = 5;
                    19:          sep = ".";
                    20, 21, 22:  f = 6;
                    default:     sep = "Z";
                endcase
                if (f < 0)
                begin
                    if (c != sep)
                        syntax_seen = 1'b1;
                end
                else if (c >= "0" && c <= "9")
                    acc[f] = acc[f] * 10 + (c - "0");
                else
                    syntax_seen = 1'b1;
                scan_pos++;
            end
            if (!last)
                return;

            y  = acc[0];
            mo = acc[1];
            d  = acc[2];
            h  = acc[3];
            mi = acc[4];
            s  = acc[5];
            ms = acc[6];
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            case (mo)
                1, 3, 5, 7, 8, 10, 12: mlen = 31;
                4, 6, 9, 11:           mlen = 30;
                2:                     mlen = leap ? 29 : 28;
                default:               mlen = 0;
            endcase
            ok = !over_seen && !syntax_seen && entry_pos == 23 &&
                 y >= 1970 && y >= cfg_min && y <= cfg_max &&
                 mo >= 1 && mo <= 12 && d >= 1 && d <= mlen &&
                 h <= 23 && mi <= 59 && s <= 59 && ms <= 999;

            res = '0;
            if (ok) begin
                secs = days_since_epoch(y, mo, d) * 86400 + h * 3600 + mi * 60 + s;
                res.ok     = 1'b1;
                res.year   = y;
                res.month  = mo;
                res.day    = d;
                res.hour   = h;
                res.minute = mi;
                res.second = s;
                res.milli  = ms;
                res.epoch  = secs[EPOCH_W-1:0];
            end
            if (role) begin
                res.win = ok && src_valid && res.milli == src_milli &&
                          longint'(res.epoch) == longint'(src_secs) + longint'(cfg_window);
            end
            else begin
                src_valid = ok;
                src_secs  = res.epoch;
                src_milli = res.milli;
            end

            if (known_q.size() != 0) begin
                known = known_q.pop_front();
                pending_results.push_back(known.given ? known.want : res);
            end
            else
                pending_results.push_back(res);

            scan_pos = 0;
            over_seen = 1'b0;
            syntax_seen = 1'b0;
            foreach (acc[i])
                acc[i] = '0;
        end
    endtask

    task automatic write_reg(input cfg_reg_t sel, input bit [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= data;
        @(posedge clk);
        case (sel)
            REG_YEAR_LO: cfg_min = data[YEAR_W-1:0];
            REG_YEAR_HI: cfg_max = data[YEAR_W-1:0];
            REG_WINDOW:  cfg_window = data[WINDOW_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // hold the sender until every outstanding result word has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_stamp(input char_q_t chars, input bit role, input bit given,
                              input stamp_result_t want);
        bit tx_burst;
        int gap;
        begin
            known_q.push_back('{given, want});
            tx_burst = ($urandom_range(0, 3) == 0);
            foreach (chars[i]) begin
                gap = tx_burst ? 0 : $urandom_range(0, 13);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                in_valid <= 1'b1;
                char_code <= chars[i];
                last_char <= (i == chars.size() - 1);
                // role only matters on the final word
                stamp_role <= (i == chars.size() - 1) ? role : 1'($urandom_range(0, 1));
                @(posedge clk);
                while (in_stall)
                    @(posedge clk);
            end
        end
    endtask

    always @(posedge clk) begin : char_monitor
        if (rst_n && in_valid && !in_stall)
            parse_char(char_code, last_char, stamp_role);
    end

    always @(posedge clk) begin : result_monitor
        stamp_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result word, year_out %0d", year_out));
            else begin
                want = pending_results.pop_front();
                if (format_ok !== want.ok)
                    report_mismatch($sformatf("format_ok %b, want %b", format_ok, want.ok));
                if (year_out !== want.year)
                    report_mismatch($sformatf("year_out %0d, want %0d", year_out, want.year));
                if (month_out !== want.month)
                    report_mismatch($sformatf("month_out %0d, want %0d", month_out, want.month));
                if (day_out !== want.day)
                    report_mismatch($sformatf("day_out %0d, want %0d", day_out, want.day));
                if (hour_out !== want.hour)
                    report_mismatch($sformatf("hour_out %0d, want %0d", hour_out, want.hour));
                if (minute_out !== want.minute)
                    report_mismatch($sformatf("minute_out %0d, want %0d",
                                              minute_out, want.minute));
                if (second_out !== want.second)
                    report_mismatch($sformatf("second_out %0d, want %0d",
                                              second_out, want.second));
                if (milli_out !== want.milli)
                    report_mismatch($sformatf("milli_out %0d, want %0d", milli_out, want.milli));
                if (epoch_seconds !== want.epoch)
                    report_mismatch($sformatf("epoch_seconds %0d, want %0d",
                                              epoch_seconds, want.epoch));
                if (window_ok !== want.win)
                    report_mismatch($sformatf("window_ok %b, want %b", window_ok, want.win));
            end
        end
    end

    // result side: random stall per word, with runs of no stall
    initial begin : result_sink
        int  n;
        bit  rx_burst;
        rx_burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            n = rx_burst ? 0 : $urandom_range(0, 13);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("utc_timestamp_parser: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int              phase_chars;
        int              pick;
        int              sub;
        int              y;
        int              mo;
        int              d;
        int              h;
        int              mi;
        int              s;
        int              ms;
        int              lo;
        int              hi;
        int              min_v;
        int              max_v;
        int              win_v;
        longint          e;
        longint          src_epoch;
        int              src_ms;
        bit              role;
        string           text;
        char_q_t         chars;

        src_epoch = 0;
        src_ms = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(plan[i].sel, plan[i].value);
            end
            else
                send_stamp(to_chars(plan[i].text), plan[i].role, plan[i].given,
                           plan[i].want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0:       min_v = 1970;
                1:       min_v = $urandom_range(1970, 2100);
                2:       min_v = $urandom_range(2000, 9999);
                3:       min_v = $urandom_range(0, 1969);
                default: min_v = $urandom_range(1970, 3000);
            endcase
            case ($urandom_range(0, 3))
                0:       max_v = 9999;
                1:       max_v = $urandom_range(min_v, 9999);
                2:       max_v = $urandom_range(1970, 2200);
                default: max_v = $urandom_range(10000, 16383);
            endcase
            case ($urandom_range(0, 3))
                0:       win_v = 0;
                1:       win_v = 65535;
                2:       win_v = $urandom_range(0, 65535);
                default: win_v = $urandom_range(0, 120);
            endcase
            // upper data bits above the 14-bit year registers are don't-care
            write_reg(REG_YEAR_LO, {2'($urandom_range(0, 3)), 14'(min_v)});
            write_reg(REG_YEAR_HI, {2'($urandom_range(0, 3)), 14'(max_v)});
            write_reg(REG_WINDOW, 16'(win_v));

            phase_chars = 0;
            while (phase_chars < PHASE_CHARS) begin
                if ($urandom_range(0, 11) == 0)
                    wait_idle();
                pick = $urandom_range(0, 99);
                role = 1'b0;
                lo = cfg_min;
                hi = (cfg_max > 9999) ? 9999 : cfg_max;
                if (lo <= hi && $urandom_range(0, 4) != 0)
                    y = $urandom_range((lo > 0) ? lo - 1 : 0, (hi < 9999) ? hi + 1 : 9999);
                else
                    y = $urandom_range(0, 9999);
                mo = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
                d  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
                h  = ($urandom_range(0, 15) == 0) ? $urandom_range(24, 99)
                                                  : $urandom_range(0, 23);
                mi = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 99)
                                                  : $urandom_range(0, 59);
                s  = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 99)
                                                  : $urandom_range(0, 59);
                ms = $urandom_range(0, 999);
                text = stamp_text(y, mo, d, h, mi, s, ms);

                if (pick < 40) begin
                    if (y >= 1970 && mo >= 1 && mo <= 12 && d >= 1 && d <= 31 &&
                        h <= 23 && mi <= 59 && s <= 59)
                    begin
                        src_epoch = days_since_epoch(y, mo, d) * 86400 +
                                    h * 3600 + mi * 60 + s;
                        src_ms = ms;
                    end
                end
                else if (pick < 75) begin
                    role = 1'b1;
                    sub = $urandom_range(0, 9);
                    e = src_epoch + cfg_window;
                    if (sub < 7)
                        text = stamp_from_epoch(e, src_ms);
                    else if (sub == 7)
                        text = stamp_from_epoch(e, (src_ms + $urandom_range(1, 999)) % 1000);
                    else if (sub == 8)
                        text = stamp_from_epoch((e > 0 && $urandom_range(0, 1)) ? e - 1 : e + 1,
                                                src_ms);
                end
                chars = to_chars(text);

                // malformed words: bad byte, short, long, or plain garbage
                if (pick >= 75) begin
                    role = $urandom_range(0, 1);
                    case ($urandom_range(0, 3))
                        0: chars[$urandom_range(0, 23)] = $urandom_range(0, 255);
                        1: chars = chars[0:$urandom_range(0, 22)];
                        2: repeat ($urandom_range(1, 8)) chars.push_back($urandom_range(0, 255));
                        default:
                        begin
                            chars.delete();
                            repeat ($urandom_range(1, 30))
                                chars.push_back($urandom_range(0, 255));
                        end
                    endcase
                end
                send_stamp(chars, role, 1'b0, NO_STAMP);
                phase_chars += chars.size();
            end
        end

        wait_idle();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
        if (mismatches == 0)
            $display("utc_timestamp_parser: match");
        else
            $display("utc_timestamp_parser: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/utcts_pkg.sv
rtl/utcts_front.sv
rtl/utcts_fifo.sv
rtl/utcts_back.sv
rtl/utc_timestamp_parser.sv
bench/tb_utc_timestamp_parser.sv
